### design/matrix_multiply_row_block_unit_defines.svh
// assertion macros for the row block matrix product unit
`ifndef MATRIX_MULTIPLY_ROW_BLOCK_UNIT_DEFINES_SVH
`define MATRIX_MULTIPLY_ROW_BLOCK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// plain property checked on every clock edge out of reset
`define MMRB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition that must hold in the cycle after the trigger
`define MMRB_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);
`else
`define MMRB_ASSERT(lbl, prop, msg)
`define MMRB_ASSERT_NEXT(lbl, trig, cons, msg)
`endif

`endif

### design/mmrb_pkg.sv
`default_nettype none
package mmrb_pkg;

	localparam int DIM        = 8;
	localparam int IDX_W      = 3;
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int VAL_W      = 16;
	localparam int PROD_W     = 2 * VAL_W;
	localparam int SUM_W      = 35;
	localparam int CMD_DEPTH  = 4;
	localparam int RES_DEPTH  = 2;
	localparam int CREDIT_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam int CNT_W      = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD_A  = 2'd0,
		OP_LOAD_B  = 2'd1,
		OP_COMPUTE = 2'd2
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		op_t                     kind;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [SUM_W-1:0] sum;
		logic                    last;
	} res_t;

	// travels alongside the operand reads through the mac pipeline
	typedef struct packed {
		logic             valid;
		logic             kfirst;
		logic             kend;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} tag_t;

	typedef struct packed {
		logic                busy;
		logic [CREDIT_W-1:0] credits;
	} back_status_t;

endpackage
`default_nettype wire

### design/matrix_multiply_row_block_unit.sv
// channel   dir  handshake             payload
// in        in   in_valid / in_ready   op, row, col, value
// out       out  out_valid / out_ready out_row, out_col, sum, last
// cfg       in   cfg_we                cfg_index, cfg_data
//
// loads are queued and written one per cycle, in order with compute commands, while no band runs
// a compute command walks its band one a*b term per cycle through the single mac,
// held while no result slot is free; results pass s1 read, s2 product, accumulate
// reset clears control and queues, sets config to first row 0, row count 8; operand stores hold garbage
// a stalled output fills a two-entry result queue, then the mac waits while
// the command queue keeps taking up to four beats
`default_nettype none
`include "matrix_multiply_row_block_unit_defines.svh"
module matrix_multiply_row_block_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [1:0]                            op,
	input  wire logic [mmrb_pkg::IDX_W-1:0]            row,
	input  wire logic [mmrb_pkg::IDX_W-1:0]            col,
	input  wire logic signed [mmrb_pkg::VAL_W-1:0]     value,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [mmrb_pkg::IDX_W-1:0]                 out_row,
	output logic [mmrb_pkg::IDX_W-1:0]                 out_col,
	output logic signed [mmrb_pkg::SUM_W-1:0]          sum,
	output logic                                       last,
	input  wire logic                                  cfg_we,
	input  wire logic [mmrb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [mmrb_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic [mmrb_pkg::IDX_W-1:0] first_row_q;
	logic [mmrb_pkg::CNT_W-1:0] row_count_q;

	logic                  cmd_valid;
	logic                  cmd_ready;
	mmrb_pkg::cmd_t        cmd;
	mmrb_pkg::res_t        res;
	mmrb_pkg::back_status_t back_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_row_q <= '0;
			row_count_q <= mmrb_pkg::CNT_W'(mmrb_pkg::DIM);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mmrb_pkg::REG_FIRST_ROW: first_row_q <= cfg_data[mmrb_pkg::IDX_W-1:0];
				mmrb_pkg::REG_ROW_COUNT: row_count_q <= cfg_data[mmrb_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	mmrb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.row      (row),
		.col      (col),
		.value    (value),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	mmrb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.first_row(first_row_q),
		.row_count(row_count_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res      (res),
		.status   (back_status)
	);

	assign out_row = res.row;
	assign out_col = res.col;
	assign sum     = res.sum;
	assign last    = res.last;

	`MMRB_ASSERT(a_credit_bound, back_status.credits <= 2'd2, "result slots overbooked")
	`MMRB_ASSERT(a_no_credit_no_out, (back_status.credits == 2'd0) |-> !out_valid, "result without slot")
	`MMRB_ASSERT(a_run_holds_queue, (back_status.busy && !cmd_ready) |-> !(cmd_valid && cmd_ready), "command taken while running")
	`MMRB_ASSERT_NEXT(a_full_stays, (back_status.credits == 2'd2) && !(out_valid && out_ready), back_status.credits == 2'd2, "element started with no free slot")

endmodule
`default_nettype wire

### design/mmrb_fifo.sv
`default_nettype none
module mmrb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### design/mmrb_front.sv
`default_nettype none
module mmrb_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       op,
	input  wire logic [mmrb_pkg::IDX_W-1:0]       row,
	input  wire logic [mmrb_pkg::IDX_W-1:0]       col,
	input  wire logic signed [mmrb_pkg::VAL_W-1:0] value,
	output logic                                  cmd_valid,
	input  wire logic                             cmd_ready,
	output mmrb_pkg::cmd_t                        cmd
);

	mmrb_pkg::cmd_t cmd_in;
	logic           keep;
	logic           full;
	logic           empty;
	logic [$bits(mmrb_pkg::cmd_t)-1:0] pop_bits;

	// unused opcode is taken and dropped here
	always_comb begin
		unique case (op)
			mmrb_pkg::OP_LOAD_A,
			mmrb_pkg::OP_LOAD_B,
			mmrb_pkg::OP_COMPUTE: keep = 1'b1;
			default:              keep = 1'b0;
		endcase
	end

	assign cmd_in.kind  = mmrb_pkg::op_t'(op);
	assign cmd_in.row   = row;
	assign cmd_in.col   = col;
	assign cmd_in.value = value;

	assign in_ready = !full;

	mmrb_fifo #(
		.WIDTH($bits(mmrb_pkg::cmd_t)),
		.DEPTH(mmrb_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid && keep),
		.push_data(cmd_in),
		.full     (full),
		.pop      (cmd_ready),
		.pop_data (pop_bits),
		.empty    (empty)
	);

	assign cmd_valid = !empty;
	assign cmd       = mmrb_pkg::cmd_t'(pop_bits);

endmodule
`default_nettype wire

### design/mmrb_back.sv
`default_nettype none
module mmrb_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cmd_valid,
	output logic                                 cmd_ready,
	input  wire mmrb_pkg::cmd_t                  cmd,
	input  wire logic [mmrb_pkg::IDX_W-1:0]      first_row,
	input  wire logic [mmrb_pkg::CNT_W-1:0]      row_count,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output mmrb_pkg::res_t                       res,
	output mmrb_pkg::back_status_t               status
);

	localparam int IDX_W  = mmrb_pkg::IDX_W;
	localparam int VAL_W  = mmrb_pkg::VAL_W;
	localparam int PROD_W = mmrb_pkg::PROD_W;
	localparam int SUM_W  = mmrb_pkg::SUM_W;
	localparam int CNT_W  = mmrb_pkg::CNT_W;
	localparam int CR_W   = mmrb_pkg::CREDIT_W;
	localparam int DEPTH  = mmrb_pkg::DIM * mmrb_pkg::DIM;

	mmrb_pkg::state_t state_q;
	mmrb_pkg::state_t state_d;

	logic [VAL_W-1:0] a_mem [DEPTH];
	logic [VAL_W-1:0] b_mem [DEPTH];

	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] last_row_q;
	logic [CR_W-1:0]  credits_q;

	logic [CNT_W:0]   end_sum;
	logic [CNT_W-1:0] band_end;
	logic             band_ok;

	logic             issue;
	logic             wr_a;
	logic             wr_b;
	logic             start_run;
	logic             k_wrap;
	logic             j_wrap;

	logic signed [VAL_W-1:0]  rd_a_s1;
	logic signed [VAL_W-1:0]  rd_b_s1;
	mmrb_pkg::tag_t           tag_s1;
	logic signed [PROD_W-1:0] prod_s2;
	mmrb_pkg::tag_t           tag_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  acc_sum;

	mmrb_pkg::res_t res_in;
	logic           res_full;
	logic           res_empty;
	logic [$bits(mmrb_pkg::res_t)-1:0] res_bits;

	// band clipped at the matrix edge
	assign end_sum  = (CNT_W + 1)'(first_row) + (CNT_W + 1)'(row_count);
	assign band_end = (end_sum > (CNT_W + 1)'(mmrb_pkg::DIM)) ?
		CNT_W'(mmrb_pkg::DIM) : end_sum[CNT_W-1:0];
	assign band_ok  = CNT_W'(first_row) < band_end;

	assign k_wrap = (k_q == IDX_W'(mmrb_pkg::DIM - 1));
	assign j_wrap = (j_q == IDX_W'(mmrb_pkg::DIM - 1));

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		issue     = 1'b0;
		wr_a      = 1'b0;
		wr_b      = 1'b0;
		start_run = 1'b0;
		unique case (state_q)
			mmrb_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					unique case (cmd.kind)
						mmrb_pkg::OP_LOAD_A:  wr_a = 1'b1;
						mmrb_pkg::OP_LOAD_B:  wr_b = 1'b1;
						mmrb_pkg::OP_COMPUTE: begin
							if (band_ok) begin
								start_run = 1'b1;
								state_d   = mmrb_pkg::ST_RUN;
							end
						end
						default: ;
					endcase
				end
			end
			mmrb_pkg::ST_RUN: begin
				// a new element starts only with a result slot reserved for it
				issue = !((k_q == '0) && (credits_q >= CR_W'(mmrb_pkg::RES_DEPTH)));
				if (issue && k_wrap && j_wrap && (i_q == last_row_q)) begin
					state_d = mmrb_pkg::ST_IDLE;
				end
			end
			default: state_d = mmrb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mmrb_pkg::ST_IDLE;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			last_row_q <= '0;
		end else begin
			state_q <= state_d;
			if (start_run) begin
				i_q        <= first_row;
				j_q        <= '0;
				k_q        <= '0;
				last_row_q <= IDX_W'(band_end - 1'b1);
			end else if (issue) begin
				k_q <= k_wrap ? '0 : k_q + 1'b1;
				if (k_wrap) begin
					j_q <= j_wrap ? '0 : j_q + 1'b1;
					if (j_wrap) begin
						i_q <= i_q + 1'b1;
					end
				end
			end
		end
	end

	// operand stores, registered read
	always_ff @(posedge clk) begin
		if (wr_a) begin
			a_mem[{cmd.row, cmd.col}] <= cmd.value;
		end
		if (issue) begin
			rd_a_s1 <= a_mem[{i_q, k_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			b_mem[{cmd.row, cmd.col}] <= cmd.value;
		end
		if (issue) begin
			rd_b_s1 <= b_mem[{k_q, j_q}];
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= rd_a_s1 * rd_b_s1;
		if (tag_s2.valid) begin
			acc_q <= acc_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1.valid  <= issue;
			tag_s1.kfirst <= (k_q == '0);
			tag_s1.kend   <= k_wrap;
			tag_s1.row    <= i_q;
			tag_s1.col    <= j_q;
			tag_s1.last   <= j_wrap && (i_q == last_row_q);
			tag_s2        <= tag_s1;
		end
	end

	assign acc_sum = (tag_s2.kfirst ? '0 : acc_q) +
		{{(SUM_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	assign res_in.row  = tag_s2.row;
	assign res_in.col  = tag_s2.col;
	assign res_in.sum  = acc_sum;
	assign res_in.last = tag_s2.last;

	mmrb_fifo #(
		.WIDTH($bits(mmrb_pkg::res_t)),
		.DEPTH(mmrb_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (tag_s2.valid && tag_s2.kend),
		.push_data(res_in),
		.full     (res_full),
		.pop      (out_ready),
		.pop_data (res_bits),
		.empty    (res_empty)
	);

	assign out_valid = !res_empty;
	assign res       = mmrb_pkg::res_t'(res_bits);

	// slots held by results queued or still in the mac pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credits_q <= '0;
		end else begin
			unique case ({issue && (k_q == '0), out_valid && out_ready})
				2'b10:   credits_q <= credits_q + 1'b1;
				2'b01:   credits_q <= credits_q - 1'b1;
				default: credits_q <= credits_q;
			endcase
		end
	end

	assign status.busy    = (state_q == mmrb_pkg::ST_RUN) || res_full;
	assign status.credits = credits_q;

endmodule
`default_nettype wire

### bench/mmrb_product_checker.sv
module mmrb_product_checker
	import mmrb_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_ready,
	input  wire logic [1:0]                  op,
	input  wire logic [IDX_W-1:0]            row,
	input  wire logic [IDX_W-1:0]            col,
	input  wire logic signed [VAL_W-1:0]     value,
	input  wire logic                        out_valid,
	input  wire logic                        out_ready,
	input  wire logic [IDX_W-1:0]            out_row,
	input  wire logic [IDX_W-1:0]            out_col,
	input  wire logic signed [SUM_W-1:0]     sum,
	input  wire logic                        last,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_DATA_W-1:0]       cfg_data,
	output int                               mismatch_count,
	output int                               results_owed,
	output int                               results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BAND_RESULTS = 64;

	logic signed [VAL_W-1:0] a_elem [DIM][DIM];
	logic signed [VAL_W-1:0] b_elem [DIM][DIM];
	logic [IDX_W-1:0]        band_first;
	logic [CNT_W-1:0]        band_rows;
	res_t                    owed_q [$];
	int                      n_bad = 0;
	int                      n_ok = 0;

	task automatic report_mismatch(input string what);
		$display("%0t ns mismatch: %s", $realtime, what);
		n_bad++;
	endtask

	// queue every element of the current row band, row-major, last one flagged
	task automatic predict_band();
		int    band_end;
		int    total;
		int    n;
		int    i;
		int    j;
		int    k;
		longint acc;
		res_t  elem;
		band_end = int'(band_first) + int'(band_rows);
		if (band_end > DIM)
			band_end = DIM;
		total = (band_end > int'(band_first)) ? (band_end - int'(band_first)) * DIM : 0;
		if (total > MAX_BAND_RESULTS)
			total = MAX_BAND_RESULTS;
		n = 0;
		for (i = int'(band_first); i < band_end && n < total; i++) begin
			for (j = 0; j < DIM && n < total; j++) begin
				acc = 0;
				for (k = 0; k < DIM; k++)
					acc += longint'(a_elem[i][k]) * longint'(b_elem[k][j]);
				elem.row = IDX_W'(i);
				elem.col = IDX_W'(j);
				elem.sum = SUM_W'(acc);
				elem.last = (n == total - 1);
				owed_q.push_back(elem);
				n++;
			end
		end
	endtask

	task automatic check_result();
		res_t want;
		if (owed_q.size() == 0) begin
			report_mismatch($sformatf("result row %0d col %0d with nothing owed",
				out_row, out_col));
		end else begin
			want = owed_q.pop_front();
			if (out_row !== want.row)
				report_mismatch($sformatf("out_row %0d, want %0d", out_row, want.row));
			if (out_col !== want.col)
				report_mismatch($sformatf("out_col %0d, want %0d", out_col, want.col));
			if (sum !== want.sum)
				report_mismatch($sformatf("sum %0d at (%0d,%0d), want %0d",
					sum, want.row, want.col, want.sum));
			if (last !== want.last)
				report_mismatch($sformatf("last %b at (%0d,%0d), want %b",
					last, want.row, want.col, want.last));
		end
		n_ok++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_first = '0;
			band_rows = CNT_W'(DIM);
			owed_q.delete();
			results_owed <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST_ROW: band_first = cfg_data[IDX_W-1:0];
					REG_ROW_COUNT: band_rows = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready) begin
				case (op)
					OP_LOAD_A:  a_elem[row][col] = value;
					OP_LOAD_B:  b_elem[row][col] = value;
					OP_COMPUTE: predict_band();
					default: ;
				endcase
			end
			results_owed <= owed_q.size();
			results_checked <= n_ok;
			mismatch_count <= n_bad;
		end
	end

endmodule

### bench/tb_matrix_multiply_row_block_unit.sv
module tb_matrix_multiply_row_block_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import mmrb_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int N_PHASES       = 10;
	localparam int PHASE_ITEMS    = 28;
	localparam int SETTLE_CYCLES  = 32;
	localparam int CYCLE_LIMIT    = 2000000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [1:0]                  op = OP_LOAD_A;
	logic [IDX_W-1:0]            row = '0;
	logic [IDX_W-1:0]            col = '0;
	logic signed [VAL_W-1:0]     value = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [IDX_W-1:0]            out_row;
	logic [IDX_W-1:0]            out_col;
	logic signed [SUM_W-1:0]     sum;
	logic                        last;
	logic                        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = REG_FIRST_ROW;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;

	int mismatch_count;
	int results_owed;
	int results_checked;
	int sender_gap_pct = 0;
	int recv_stall_pct = 0;
	int beats_sent = 0;
	int cycle_count = 0;

	matrix_multiply_row_block_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.row       (row),
		.col       (col),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_row   (out_row),
		.out_col   (out_col),
		.sum       (sum),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mmrb_product_checker product_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.row             (row),
		.col             (col),
		.value           (value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_row         (out_row),
		.out_col         (out_col),
		.sum             (sum),
		.last            (last),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.results_owed    (results_owed),
		.results_checked (results_checked)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed",
				cycle_count, results_owed);
			$display("tb_matrix_multiply_row_block_unit: FAIL");
			$finish;
		end
	end

	task automatic apply_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin sender_gap_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SENDER:   begin sender_gap_pct = 69; recv_stall_pct = 0;  end
			IDLE_RECEIVER: begin sender_gap_pct = 0;  recv_stall_pct = 69; end
			default:       begin sender_gap_pct = 17; recv_stall_pct = 17; end
		endcase
	endtask

	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// one input beat, with a random gap in front of it
	task automatic send_beat(input logic [1:0] code, input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c, input logic signed [VAL_W-1:0] v);
		while ($urandom_range(0, 99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		row <= r;
		col <= c;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic send_random_item(output bit counted);
		int pick;
		pick = $urandom_range(0, 99);
		counted = 1'b1;
		if (pick < 6) begin
			send_beat(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), rand_value());
			counted = 1'b0;
		end else if (pick < 18) begin
			send_beat(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), rand_value());
		end else begin
			send_beat($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
				IDX_W'($urandom), IDX_W'($urandom), rand_value());
		end
	endtask

	// pause the sender until every owed result is back and the block is quiet
	task automatic wait_results_done();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_band(input logic [CFG_DATA_W-1:0] first_data,
		input logic [CFG_DATA_W-1:0] count);
		cfg_we <= 1'b1;
		cfg_index <= REG_FIRST_ROW;
		cfg_data <= first_data;
		@(posedge clk);
		cfg_index <= REG_ROW_COUNT;
		cfg_data <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// {first_row data, row_count}; top bit of first_row data is don't-care
	function automatic logic [7:0] phase_band(input int p);
		case (p)
			0: return {4'd0, 4'd8};
			1: return {4'd7, 4'd1};
			2: return {4'd11, 4'd15};
			3: return {4'd5, 4'd0};
			4: return {4'd8, 4'd1};
			5: return {4'd15, 4'd8};
			6: return {4'd2, 4'd3};
			7: return {4'd4, 4'd2};
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		int   r;
		int   c;
		int   p;
		int   done_items;
		bit   counted;
		logic [7:0] band;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill both stores so no compute ever reads an unwritten entry;
		// rows 6/7 of a and column 7 of b give the largest sums of both signs
		apply_idle(IDLE_NONE);
		for (r = 0; r < DIM; r++)
			for (c = 0; c < DIM; c++)
				send_beat(OP_LOAD_A, IDX_W'(r), IDX_W'(c),
					(r == 7) ? 16'sh8000 : (r == 6) ? 16'sh7fff : rand_value());
		for (r = 0; r < DIM; r++)
			for (c = 0; c < DIM; c++)
				send_beat(OP_LOAD_B, IDX_W'(r), IDX_W'(c),
					(c == 7) ? 16'sh8000 : rand_value());

		apply_idle(IDLE_BOTH);
		send_beat(OP_COMPUTE, 3'd7, 3'd7, 16'shffff);
		send_beat(OP_UNUSED, 3'd7, 3'd0, 16'sh8000);
		send_beat(OP_LOAD_A, 3'd0, 3'd0, 16'sh7fff);
		send_beat(OP_LOAD_B, 3'd0, 3'd0, 16'sh8000);
		send_beat(OP_LOAD_B, 3'd7, 3'd7, 16'sh0000);
		send_beat(OP_LOAD_A, 3'd7, 3'd7, 16'shffff);
		send_beat(OP_LOAD_A, 3'd3, 3'd4, 16'sh0001);
		send_beat(OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
		send_beat(OP_COMPUTE, 3'd5, 3'd2, 16'sh7fff);
		send_beat(OP_LOAD_B, 3'd4, 3'd1, 16'sh8000);
		send_beat(OP_COMPUTE, 3'd0, 3'd7, 16'sh8000);
		wait_results_done();

		for (p = 0; p < N_PHASES; p++) begin
			band = phase_band(p);
			set_band(band[7:4], band[3:0]);
			apply_idle(idle_mode_t'(p % 4));
			done_items = 0;
			while (done_items < PHASE_ITEMS) begin
				send_random_item(counted);
				if (counted)
					done_items++;
			end
			wait_results_done();
		end

		$display("summary: %0d input beats, %0d results checked in %0d cycles",
			beats_sent, results_checked, cycle_count);
		$display("summary: %0d band settings incl. empty and clipped bands, all idle mixes",
			N_PHASES + 1);
		if (mismatch_count == 0 && results_owed == 0)
			$display("tb_matrix_multiply_row_block_unit: PASS");
		else
			$display("tb_matrix_multiply_row_block_unit: FAIL");
		$finish;
	end

endmodule

### matrix_multiply_row_block_unit.f
+incdir+design
design/mmrb_pkg.sv
design/mmrb_fifo.sv
design/mmrb_front.sv
design/mmrb_back.sv
design/matrix_multiply_row_block_unit.sv
bench/mmrb_product_checker.sv
bench/tb_matrix_multiply_row_block_unit.sv
